FILE: rtl/rc_hopping_frame_builder_macros.svh
// Assertion macros for the hopping frame builder.
// Used by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef RC_HOPPING_FRAME_BUILDER_MACROS_SVH
`define RC_HOPPING_FRAME_BUILDER_MACROS_SVH

`ifndef SYNTHESIS
`define RCHFB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RCHFB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCHFB_ASSERT_IMP(lbl, ante, cons, msg)
`define RCHFB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/rchfb_pkg.sv
// Package for the hopping frame builder: payload structs, codes, constants,
// channel scaling constants and the hop table function. No dependencies.
`default_nettype none

package rchfb_pkg;

    localparam int FRAME_LEN  = 16;
    localparam int BYTE_IDX_W = $clog2(FRAME_LEN);

    typedef enum logic [1:0] {
        MODE_TICK       = 2'd0,
        MODE_START_DATA = 2'd1,
        MODE_START_BIND = 2'd2,
        MODE_UNUSED     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_BIND_COUNT = 2'd0,
        CFG_TX_ADDRESS = 2'd1,
        CFG_HOP_OFFSET = 2'd2,
        CFG_HOP_ORDER  = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 40;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] ch_aileron;
        logic signed [15:0] ch_elevator;
        logic signed [15:0] ch_throttle;
        logic signed [15:0] ch_rudder;
        logic signed [15:0] ch_calibrate;
    } in_item_t;

    typedef struct packed {
        logic [7:0]            frame_byte;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic                  last_byte;
        logic                  is_bind_frame;
        logic [6:0]            radio_channel;
        logic [15:0]           next_period_us;
    } out_item_t;

    typedef struct packed {
        logic        is_bind_frame;
        logic [6:0]  radio_channel;
        logic [15:0] next_period_us;
    } frame_meta_t;

    typedef logic [FRAME_LEN-1:0][7:0] frame_bytes_t;

    localparam logic [7:0]  SIG_BYTE0        = 8'h42;
    localparam logic [7:0]  SIG_BYTE1        = 8'h4E;
    localparam logic [7:0]  SIG_BYTE2        = 8'h44;
    localparam logic [7:0]  DATA_BYTE1       = 8'h04;
    localparam logic [7:0]  CAL_FLAG         = 8'h01;
    localparam logic [6:0]  HOP_BASE         = 7'h10;
    localparam logic [6:0]  HOP_STEP         = 7'd5;
    localparam logic [6:0]  BIND_RADIO_CH    = 7'd35;
    localparam logic [15:0] DATA_PERIOD      = 16'd5000;
    localparam logic [15:0] BIND_PERIOD      = 16'd3300;
    localparam logic [15:0] SLOW_PERIOD      = 16'd9900;
    localparam logic [15:0] SLOW_AT          = 16'd100;
    localparam logic [15:0] BIND_COUNT_RESET = 16'd1000;

    localparam int                 FULL_SCALE_W = 11;
    localparam logic [10:0]        FULL_SCALE   = 11'h7FF;
    localparam int                 CHAN_LOW_LIMIT  = -10000;
    localparam int                 CHAN_HIGH_LIMIT = 10000;
    localparam logic signed [15:0] CHAN_LOW16   = 16'(CHAN_LOW_LIMIT);
    localparam logic signed [15:0] CHAN_HIGH16  = 16'(CHAN_HIGH_LIMIT);

    // floor(x / SPAN) == (x * RECIP) >> SHIFT for every x the scaler produces
    localparam longint unsigned CHAN_SPAN   = longint'(CHAN_HIGH_LIMIT - CHAN_LOW_LIMIT);
    localparam int              SCALE_SHIFT = 44;
    localparam longint unsigned SCALE_RECIP =
        ((64'd1 << SCALE_SHIFT) + CHAN_SPAN - 64'd1) / CHAN_SPAN;
    localparam int SCALE_RECIP_W = $clog2(SCALE_RECIP + 64'd1);
    localparam int SCALE_NUM_W   = 16 + FULL_SCALE_W;
    localparam int SCALE_PROD_W  = SCALE_NUM_W + SCALE_RECIP_W;

    function automatic logic [6:0] hop_entry(input logic [2:0] slot,
                                             input logic [2:0] offset);
        logic [6:0] e;
        e = HOP_BASE + HOP_STEP * 7'(slot) + 7'(offset);
        if (offset == 3'd0 && slot == 3'd0)
        begin
            e = e + 7'd1;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rchfb_chan_scale.sv
// One channel lane: clamp, scale to 11 bits by reciprocal multiply, optional reverse.
// Depends on rchfb_pkg.
`default_nettype none

module rchfb_chan_scale
    import rchfb_pkg::*;
(
    input  logic signed [15:0]       raw,
    input  logic                     reversed,
    output logic [FULL_SCALE_W-1:0]  value
);

    logic signed [15:0]        clamped;
    logic signed [16:0]        diff;
    logic [15:0]               offs;
    logic [SCALE_NUM_W-1:0]    num;
    logic [SCALE_PROD_W-1:0]   prod;
    logic [FULL_SCALE_W-1:0]   scaled;

    always_comb
    begin
        if (raw < CHAN_LOW16)
        begin
            clamped = CHAN_LOW16;
        end
        else if (raw > CHAN_HIGH16)
        begin
            clamped = CHAN_HIGH16;
        end
        else
        begin
            clamped = raw;
        end
    end

    assign diff   = 17'(clamped) - 17'(CHAN_LOW16);
    assign offs   = diff[15:0];
    assign num    = {offs, FULL_SCALE_W'(0)} - SCALE_NUM_W'(offs);
    assign prod   = SCALE_PROD_W'(num) * SCALE_PROD_W'(SCALE_RECIP);
    assign scaled = FULL_SCALE_W'(prod >> SCALE_SHIFT);
    assign value  = reversed ? (FULL_SCALE - scaled) : scaled;

endmodule

`default_nettype wire

FILE: rtl/rchfb_frame_seq.sv
// Configuration registers, phase and hop state, and the frame assembly for one item.
// Depends on rchfb_pkg, rchfb_chan_scale and the assertion macro header.
`default_nettype none
`include "rc_hopping_frame_builder_macros.svh"

module rchfb_frame_seq
    import rchfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_item_t              item,
    input  logic                  step,
    output logic                  has_result,
    output frame_bytes_t          frame,
    output frame_meta_t           meta
);

    logic [15:0] bind_count_reg;
    logic [39:0] tx_address_reg;
    logic [2:0]  hop_offset_reg;
    logic [1:0]  hop_order_reg;

    logic        in_bind_reg, in_bind_next;
    logic [15:0] bind_remaining_reg, bind_remaining_next;
    logic [2:0]  hop_slot_reg, hop_slot_next;
    logic [15:0] tick_period_reg, tick_period_next;

    logic [2:0]  slot_c;
    logic [15:0] remaining_dec;
    logic        data_tick;
    logic [FULL_SCALE_W-1:0] thr, ail, ele, rud;
    frame_bytes_t bind_frame;
    frame_bytes_t data_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bind_count_reg <= BIND_COUNT_RESET;
            tx_address_reg <= '0;
            hop_offset_reg <= '0;
            hop_order_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_BIND_COUNT: bind_count_reg <= cfg_data[15:0];
                CFG_TX_ADDRESS: tx_address_reg <= cfg_data[39:0];
                CFG_HOP_OFFSET: hop_offset_reg <= cfg_data[2:0];
                CFG_HOP_ORDER:  hop_order_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    rchfb_chan_scale u_thr (.raw(item.ch_throttle), .reversed(1'b0), .value(thr));
    rchfb_chan_scale u_ail (.raw(item.ch_aileron),  .reversed(1'b1), .value(ail));
    rchfb_chan_scale u_ele (.raw(item.ch_elevator), .reversed(1'b0), .value(ele));
    rchfb_chan_scale u_rud (.raw(item.ch_rudder),   .reversed(1'b1), .value(rud));

    always_comb
    begin
        slot_c = hop_slot_reg;
        if (hop_order_reg[0])
        begin
            slot_c = {~hop_slot_reg[0], hop_slot_reg[2:1]};
        end
        if (hop_order_reg[1])
        begin
            slot_c = ~slot_c;
        end
    end

    always_comb
    begin
        bind_frame    = '0;
        bind_frame[0] = SIG_BYTE0;
        bind_frame[1] = SIG_BYTE1;
        bind_frame[2] = SIG_BYTE2;
        bind_frame[3] = tx_address_reg[7:0];
        bind_frame[4] = tx_address_reg[15:8];
        bind_frame[5] = tx_address_reg[23:16];
        bind_frame[6] = tx_address_reg[31:24];
        bind_frame[7] = tx_address_reg[39:32];
        for (int i = 0; i < 8; i++)
        begin
            bind_frame[8 + i] = {1'b0, hop_entry(3'(i), hop_offset_reg)};
        end
    end

    always_comb
    begin
        data_frame     = '0;
        data_frame[0]  = {3'b000, hop_order_reg, slot_c};
        data_frame[1]  = DATA_BYTE1;
        data_frame[2]  = (item.ch_calibrate > 16'sd0) ? CAL_FLAG : 8'h00;
        data_frame[7]  = thr[7:0];
        data_frame[8]  = {ail[4:0], thr[10:8]};
        data_frame[9]  = {2'b00, ail[10:5]};
        data_frame[10] = ele[7:0];
        data_frame[11] = {rud[4:0], ele[10:8]};
        data_frame[12] = {2'b00, rud[10:5]};
    end

    assign remaining_dec = bind_remaining_reg - 16'd1;
    assign data_tick     = (item.mode == MODE_TICK) && !in_bind_reg;

    always_comb
    begin
        in_bind_next        = in_bind_reg;
        bind_remaining_next = bind_remaining_reg;
        hop_slot_next       = hop_slot_reg;
        tick_period_next    = tick_period_reg;
        has_result          = 1'b0;
        frame               = data_frame;
        meta.is_bind_frame  = 1'b0;
        meta.radio_channel  = hop_entry(slot_c, hop_offset_reg);
        unique case (item.mode)
            MODE_START_DATA:
            begin
                in_bind_next     = 1'b0;
                tick_period_next = DATA_PERIOD;
                hop_slot_next    = '0;
            end
            MODE_START_BIND:
            begin
                in_bind_next        = 1'b1;
                bind_remaining_next = bind_count_reg;
                tick_period_next    = BIND_PERIOD;
                hop_slot_next       = '0;
            end
            MODE_TICK:
            begin
                if (in_bind_reg)
                begin
                    if (bind_remaining_reg == 16'd0)
                    begin
                        in_bind_next     = 1'b0;
                        tick_period_next = DATA_PERIOD;
                    end
                    else
                    begin
                        has_result          = 1'b1;
                        bind_remaining_next = remaining_dec;
                        if (remaining_dec == SLOW_AT)
                        begin
                            tick_period_next = SLOW_PERIOD;
                        end
                        frame              = bind_frame;
                        meta.is_bind_frame = 1'b1;
                        meta.radio_channel = BIND_RADIO_CH;
                    end
                end
                else
                begin
                    has_result    = 1'b1;
                    hop_slot_next = hop_slot_reg + 3'd1;
                end
            end
            MODE_UNUSED: ;
            default: ;
        endcase
        meta.next_period_us = tick_period_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bind_reg        <= 1'b0;
            bind_remaining_reg <= '0;
            hop_slot_reg       <= '0;
            tick_period_reg    <= DATA_PERIOD;
        end
        else if (step)
        begin
            in_bind_reg        <= in_bind_next;
            bind_remaining_reg <= bind_remaining_next;
            hop_slot_reg       <= hop_slot_next;
            tick_period_reg    <= tick_period_next;
        end
    end

    `RCHFB_ASSERT_IMP(a_period_legal, 1'b1, tick_period_reg == DATA_PERIOD || tick_period_reg == BIND_PERIOD || tick_period_reg == SLOW_PERIOD, "tick period left its legal set")
    `RCHFB_ASSERT_NXT(a_bind_start, step && item.mode == MODE_START_BIND, in_bind_reg && bind_remaining_reg == $past(bind_count_reg), "bind start did not load the bind count")
    `RCHFB_ASSERT_NXT(a_slot_advance, step && data_tick, hop_slot_reg == $past(hop_slot_reg) + 3'd1, "data tick did not advance the hop slot")

endmodule

`default_nettype wire

FILE: rtl/rchfb_out_buf.sv
// Frame result register and byte serializer: holds one frame, sends one byte per beat.
// Depends on rchfb_pkg and the assertion macro header.
`default_nettype none
`include "rc_hopping_frame_builder_macros.svh"

module rchfb_out_buf
    import rchfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  frame_bytes_t frame,
    input  frame_meta_t  meta,
    output logic         frame_free,
    output logic         out_valid,
    input  logic         out_ready,
    output out_item_t    out_data
);

    localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(FRAME_LEN - 1);

    frame_bytes_t            frame_reg;
    frame_meta_t             meta_reg;
    logic                    valid_reg;
    logic [BYTE_IDX_W-1:0]   cnt_reg;
    logic                    beat;
    logic                    last;

    assign last       = (cnt_reg == LAST_IDX);
    assign beat       = valid_reg && out_ready;
    assign frame_free = !valid_reg || (beat && last);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame;
            meta_reg  <= meta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (beat)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign out_valid               = valid_reg;
    assign out_data.frame_byte     = frame_reg[cnt_reg];
    assign out_data.byte_index     = cnt_reg;
    assign out_data.last_byte      = last;
    assign out_data.is_bind_frame  = meta_reg.is_bind_frame;
    assign out_data.radio_channel  = meta_reg.radio_channel;
    assign out_data.next_period_us = meta_reg.next_period_us;

    `RCHFB_ASSERT_IMP(a_load_when_free, load, frame_free, "frame loaded over a pending frame")
    `RCHFB_ASSERT_NXT(a_byte_advance, beat && !last && !load, valid_reg && cnt_reg == $past(cnt_reg) + 1'b1, "byte index did not advance")

endmodule

`default_nettype wire

FILE: rtl/rc_hopping_frame_builder.sv
// A tick is registered on acceptance; its frame loads into the output register, making its first
// byte valid, once the serializer is free. Frame ticks are limited by the serializer sending
// one byte per beat; starts and frameless ticks pass at one per cycle after the input register.
// Reset: data phase, tick period 5000, hop slot 0, registers at their reset values.
// Holds the input register and ties frame assembly to the output serializer.
// Depends on rchfb_pkg, rchfb_frame_seq and rchfb_out_buf.
`default_nettype none

module rc_hopping_frame_builder
    import rchfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    in_item_t     in_item_reg;
    logic         in_valid_reg;
    logic         advance;
    logic         has_result;
    logic         frame_free;
    frame_bytes_t frame;
    frame_meta_t  meta;

    assign advance  = in_valid_reg && (!has_result || frame_free);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    rchfb_frame_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (in_item_reg),
        .step         (advance),
        .has_result   (has_result),
        .frame        (frame),
        .meta         (meta)
    );

    rchfb_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && has_result),
        .frame      (frame),
        .meta       (meta),
        .frame_free (frame_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire
